// ===== hw/rtl/cppr_pkg.sv =====
// Shared types and constants of the control port packet router.
`default_nettype none

package cppr_pkg;

   localparam int DATA_W  = 64;
   localparam int KEEP_W  = 8;
   localparam int PORT_W  = 16;
   localparam int ADDR_W  = 32;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 16;
   localparam int KCNT_W  = 4;

   localparam logic [PORT_W-1:0] CONTROL_PORT_RESET = 16'd5440;
   localparam logic [CODE_W-1:0] SUBMIT_CODE_RESET  = 32'd1;

   // Register index, taken from paddr[2]
   localparam logic REG_CONTROL_PORT = 1'b0;
   localparam logic REG_SUBMIT_CODE  = 1'b1;

   // Fields of the command word on a control first beat
   localparam int CODE_LSB  = 0;
   localparam int SPORT_LSB = 32;
   localparam int DPORT_LSB = 48;

   typedef enum logic [1:0] {
      CMD_RX    = 2'd0,
      CMD_TX    = 2'd1,
      CMD_REPLY = 2'd2,
      CMD_NONE  = 2'd3
   } cppr_cmd_type;

   typedef enum logic [2:0] {
      KIND_ABSORB  = 3'd0,
      KIND_RX_FWD  = 3'd1,
      KIND_COMMAND = 3'd2,
      KIND_TX_FWD  = 3'd3,
      KIND_REFUSED = 3'd4,
      KIND_IGNORED = 3'd5
   } cppr_kind_type;

   typedef enum logic [3:0] {
      RX_FIRST  = 4'b0001,
      RX_ADDR   = 4'b0010,
      RX_WAIT   = 4'b0100,
      RX_INSIDE = 4'b1000
   } cppr_rx_state_type;

   // Classified word handed from the front to the back
   typedef struct packed {
      cppr_cmd_type        cmd;
      logic [DATA_W-1:0]   data;
      logic [KEEP_W-1:0]   keep;
      logic                last;
      logic [ADDR_W-1:0]   maddr;
      logic [PORT_W-1:0]   mport;
      logic                ok;
      logic                is_ctrl;
      logic                is_submit;
      logic [KCNT_W-1:0]   kcount;
   } cppr_item_type;

   typedef struct packed {
      cppr_kind_type       kind;
      logic [DATA_W-1:0]   data;
      logic [KEEP_W-1:0]   keep;
      logic                last;
      logic [CODE_W-1:0]   code;
      logic                ports_valid;
      logic [PORT_W-1:0]   src_port;
      logic [PORT_W-1:0]   dst_port;
      logic                meta_valid;
      logic [ADDR_W-1:0]   src_addr;
      logic [ADDR_W-1:0]   dst_addr;
      logic [LEN_W-1:0]    tx_length;
   } cppr_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cppr_req_if.sv =====
// Input word channel: receive/transmit beats and command replies.
`default_nettype none

interface cppr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] beat_data;
   logic [7:0]  beat_keep;
   logic        beat_last;
   logic [31:0] meta_dest_addr;
   logic [15:0] meta_dest_port;
   logic        reply_ok;

   modport source (output valid, command, beat_data, beat_keep, beat_last,
                   meta_dest_addr, meta_dest_port, reply_ok, input ready);
   modport sink (input valid, command, beat_data, beat_keep, beat_last,
                 meta_dest_addr, meta_dest_port, reply_ok, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cppr_rsp_if.sv =====
// Result word channel.
`default_nettype none

interface cppr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [63:0] out_data;
   logic [7:0]  out_keep;
   logic        out_last;
   logic [31:0] command_code;
   logic        ports_valid;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic        meta_valid;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] tx_length;

   modport source (output valid, kind, out_data, out_keep, out_last, command_code,
                   ports_valid, src_port, dst_port, meta_valid, src_addr, dst_addr,
                   tx_length, input ready);
   modport sink (input valid, kind, out_data, out_keep, out_last, command_code,
                 ports_valid, src_port, dst_port, meta_valid, src_addr, dst_addr,
                 tx_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cppr_front.sv =====
// Front stage: accepts input words and classifies them against the config.
`default_nettype none

module cppr_front #(
   parameter int BYTES_PER_BEAT = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   cppr_req_if.sink                      req,
   input  wire logic [15:0]              control_port,
   input  wire logic [31:0]              submit_code,
   output logic                          out_valid,
   output cppr_pkg::cppr_item_type       out_item,
   input  wire logic                     out_ready
);
   import cppr_pkg::*;

   logic          valid_ff, valid_in;
   cppr_item_type item_ff, item_in;
   logic [KCNT_W-1:0] kcount;
   logic          take;

   assign req.ready = !valid_ff || out_ready;
   assign take      = req.valid && req.ready;

   // enabled bytes within the beat width
   always_comb begin
      kcount = '0;
      for (int i = 0; i < KEEP_W; i++) begin
         if (i < BYTES_PER_BEAT) begin
            kcount = kcount + {{(KCNT_W-1){1'b0}}, req.beat_keep[i]};
         end
      end
   end

   always_comb begin
      item_in.cmd       = cppr_cmd_type'(req.command);
      item_in.data      = req.beat_data;
      item_in.keep      = req.beat_keep;
      item_in.last      = req.beat_last;
      item_in.maddr     = req.meta_dest_addr;
      item_in.mport     = req.meta_dest_port;
      item_in.ok        = req.reply_ok;
      item_in.is_ctrl   = (req.meta_dest_port == control_port);
      item_in.is_submit = (req.beat_data[CODE_LSB +: CODE_W] == submit_code);
      item_in.kcount    = kcount;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cppr_queue.sv =====
// Two-entry queue between the front and back stages.
`default_nettype none

module cppr_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_valid,
   input  wire cppr_pkg::cppr_item_type  wr_item,
   output logic                          wr_ready,
   output logic                          rd_valid,
   output cppr_pkg::cppr_item_type       rd_item,
   input  wire logic                     rd_ready
);
   import cppr_pkg::*;

   cppr_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_item  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cppr_back.sv =====
// Back stage: routing state, transmit length count and the result register.
`default_nettype none

module cppr_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire cppr_pkg::cppr_item_type  in_item,
   output logic                          in_ready,
   cppr_rsp_if.source                    rsp
);
   import cppr_pkg::*;

   cppr_rx_state_type rx_state_ff, rx_state_in;
   logic              tx_inside_ff, tx_inside_in;
   logic [PORT_W-1:0] self_port_ff, self_port_in;
   logic [PORT_W-1:0] dest_port_ff, dest_port_in;
   logic [ADDR_W-1:0] self_addr_ff, self_addr_in;
   logic [ADDR_W-1:0] dest_addr_ff, dest_addr_in;
   logic [LEN_W-1:0]  byte_count_ff, byte_count_in;
   logic [LEN_W-1:0]  count_sum;
   logic              out_valid_ff, out_valid_in;
   cppr_result_type   result_ff, result_in;
   logic              pop;

   assign in_ready  = !out_valid_ff || rsp.ready;
   assign pop       = in_valid && in_ready;
   assign count_sum = byte_count_ff + {{(LEN_W-KCNT_W){1'b0}}, in_item.kcount};

   always_comb begin
      rx_state_in   = rx_state_ff;
      tx_inside_in  = tx_inside_ff;
      self_port_in  = self_port_ff;
      dest_port_in  = dest_port_ff;
      self_addr_in  = self_addr_ff;
      dest_addr_in  = dest_addr_ff;
      byte_count_in = byte_count_ff;
      result_in     = '0;
      result_in.kind = KIND_ABSORB;

      case (in_item.cmd)
         CMD_RX: begin
            case (rx_state_ff)
               RX_FIRST: begin
                  self_addr_in = in_item.maddr;
                  if (in_item.is_ctrl) begin
                     result_in.kind = KIND_COMMAND;
                     result_in.code = in_item.data[CODE_LSB +: CODE_W];
                     if (in_item.is_submit) begin
                        self_port_in          = in_item.data[SPORT_LSB +: PORT_W];
                        dest_port_in          = in_item.data[DPORT_LSB +: PORT_W];
                        result_in.ports_valid = 1'b1;
                        result_in.src_port    = in_item.data[SPORT_LSB +: PORT_W];
                        result_in.dst_port    = in_item.data[DPORT_LSB +: PORT_W];
                        rx_state_in           = RX_ADDR;
                     end else begin
                        rx_state_in = RX_WAIT;
                     end
                  end else if (in_item.mport == self_port_ff) begin
                     result_in.kind = KIND_RX_FWD;
                     result_in.data = in_item.data;
                     result_in.keep = in_item.keep;
                     result_in.last = in_item.last;
                     if (!in_item.last) begin
                        rx_state_in = RX_INSIDE;
                     end
                  end
               end
               RX_ADDR: begin
                  dest_addr_in = in_item.data[ADDR_W-1:0];
                  rx_state_in  = RX_WAIT;
               end
               RX_WAIT: begin
                  result_in.kind = KIND_REFUSED;
               end
               RX_INSIDE: begin
                  result_in.kind = KIND_RX_FWD;
                  result_in.data = in_item.data;
                  result_in.keep = in_item.keep;
                  result_in.last = in_item.last;
                  if (in_item.last) begin
                     rx_state_in = RX_FIRST;
                  end
               end
               default: begin
                  rx_state_in = RX_FIRST;
               end
            endcase
         end
         CMD_TX: begin
            result_in.kind = KIND_TX_FWD;
            result_in.data = in_item.data;
            result_in.keep = in_item.keep;
            result_in.last = in_item.last;
            if (!tx_inside_ff) begin
               result_in.meta_valid = 1'b1;
               result_in.src_port   = self_port_ff;
               result_in.dst_port   = dest_port_ff;
               result_in.src_addr   = self_addr_ff;
               result_in.dst_addr   = dest_addr_ff;
            end
            if (in_item.last) begin
               result_in.tx_length = count_sum;
               byte_count_in       = '0;
               tx_inside_in        = 1'b0;
            end else begin
               byte_count_in = count_sum;
               tx_inside_in  = 1'b1;
            end
         end
         CMD_REPLY: begin
            if (rx_state_ff == RX_WAIT) begin
               if (in_item.ok) begin
                  rx_state_in = RX_FIRST;
               end
            end else begin
               result_in.kind = KIND_IGNORED;
            end
         end
         default: begin
            result_in.kind = KIND_ABSORB;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_state_ff   <= RX_FIRST;
         tx_inside_ff  <= 1'b0;
         self_port_ff  <= '0;
         dest_port_ff  <= '0;
         self_addr_ff  <= '0;
         dest_addr_ff  <= '0;
         byte_count_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            rx_state_ff   <= rx_state_in;
            tx_inside_ff  <= tx_inside_in;
            self_port_ff  <= self_port_in;
            dest_port_ff  <= dest_port_in;
            self_addr_ff  <= self_addr_in;
            dest_addr_ff  <= dest_addr_in;
            byte_count_ff <= byte_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = result_ff.kind;
   assign rsp.out_data     = result_ff.data;
   assign rsp.out_keep     = result_ff.keep;
   assign rsp.out_last     = result_ff.last;
   assign rsp.command_code = result_ff.code;
   assign rsp.ports_valid  = result_ff.ports_valid;
   assign rsp.src_port     = result_ff.src_port;
   assign rsp.dst_port     = result_ff.dst_port;
   assign rsp.meta_valid   = result_ff.meta_valid;
   assign rsp.src_addr     = result_ff.src_addr;
   assign rsp.dst_addr     = result_ff.dst_addr;
   assign rsp.tx_length    = result_ff.tx_length;

endmodule

`default_nettype wire

// ===== hw/rtl/control_port_packet_router.sv =====
// Top level of the control port packet router: config registers and stage wiring.
//
//  channel   | direction | handshake               | carries
//  ----------+-----------+-------------------------+-------------------------------
//  req_bus   | in        | valid/ready             | rx/tx beats, command replies
//  rsp_bus   | out       | valid/ready             | one result word per input word
//  apb (p*)  | in        | psel/penable, pready=1  | control_port @0, submit_code @4
//
// One word per cycle sustained while rsp_bus is ready; a word passes the front
// register, a queue slot and the result register, in that order.
// The rate is set by the back stage, which updates the routing state and the
// transmit byte count once per word.
// Reset is synchronous and active high; config returns to port 5440 and code 1.
// A stalled rsp_bus holds its word; the two-entry queue and front register keep
// taking input until they fill, then req_bus.ready drops.
`default_nettype none

module control_port_packet_router #(
   parameter int BYTES_PER_BEAT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   cppr_req_if.sink         req_bus,
   cppr_rsp_if.source       rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import cppr_pkg::*;

   logic [PORT_W-1:0] control_port_ff, control_port_in;
   logic [CODE_W-1:0] submit_code_ff, submit_code_in;
   logic              csr_write;

   logic          front_valid;
   cppr_item_type front_item;
   logic          queue_wr_ready;
   logic          queue_rd_valid;
   cppr_item_type queue_item;
   logic          back_ready;

   // ---- config registers ----
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      control_port_in = control_port_ff;
      submit_code_in  = submit_code_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_CONTROL_PORT: control_port_in = pwdata[PORT_W-1:0];
            REG_SUBMIT_CODE:  submit_code_in  = pwdata[CODE_W-1:0];
            default:          control_port_in = control_port_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_CONTROL_PORT: prdata = {{(32-PORT_W){1'b0}}, control_port_ff};
         REG_SUBMIT_CODE:  prdata = submit_code_ff;
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_port_ff <= CONTROL_PORT_RESET;
         submit_code_ff  <= SUBMIT_CODE_RESET;
      end else begin
         control_port_ff <= control_port_in;
         submit_code_ff  <= submit_code_in;
      end
   end

   // ---- front: accept and classify ----
   cppr_front #(
      .BYTES_PER_BEAT (BYTES_PER_BEAT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .control_port (control_port_ff),
      .submit_code  (submit_code_ff),
      .out_valid    (front_valid),
      .out_item     (front_item),
      .out_ready    (queue_wr_ready)
   );

   // ---- decoupling queue ----
   cppr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_item  (front_item),
      .wr_ready (queue_wr_ready),
      .rd_valid (queue_rd_valid),
      .rd_item  (queue_item),
      .rd_ready (back_ready)
   );

   // ---- back: routing state and result ----
   cppr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_rd_valid),
      .in_item  (queue_item),
      .in_ready (back_ready),
      .rsp      (rsp_bus)
   );

endmodule

`default_nettype wire
